@@ rtl/stepper_position_follower_assert.svh @@
// assertion macros for the stepper position follower
// no dependencies; included by the rtl files that check their own logic
`ifndef STEPPER_POSITION_FOLLOWER_ASSERT_SVH
`define STEPPER_POSITION_FOLLOWER_ASSERT_SVH

`ifndef SYNTHESIS

// property checked on every clock edge outside reset
`define SPF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define SPF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SPF_ASSERT(label, clk, rst_n, prop, msg)
`define SPF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ rtl/spf_pkg.sv @@
// shared types and constants of the stepper position follower
// no dependencies; used by every rtl module of the block
`default_nettype none

package spf_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK      = 2'd0;
    localparam logic [1:0] KIND_SET_GOAL  = 2'd1;
    localparam logic [1:0] KIND_CALIBRATE = 2'd2;

    // configuration register map
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_DEG = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL_DIVIDER   = 1'd1;

    // register widths and reset values
    localparam int unsigned SPD_W    = 24;
    localparam int unsigned CALDIV_W = 8;
    localparam logic [SPD_W-1:0]    SPD_RESET    = 24'd3438617;
    localparam logic [CALDIV_W-1:0] CALDIV_RESET = 8'd20;

    // angle is signed q7.8 degrees
    localparam int unsigned ANGLE_W = 16;

    // one input beat
    typedef struct packed {
        logic [1:0]                kind;
        logic signed [ANGLE_W-1:0] angle;
        logic                      left_switch;
        logic                      right_switch;
        logic                      alarm_active;
    } t_item;

    // single-bit result flags
    typedef struct packed {
        logic step_pulse;
        logic direction;
        logic fault;
        logic calibrating;
    } t_flags;

endpackage

`default_nettype wire

@@ rtl/spf_goal_scale.sv @@
// angle to step-count conversion: q7.8 degrees times q8.16 steps per degree
// depends on spf_pkg for the angle and register widths
`default_nettype none

module spf_goal_scale #(
    parameter int unsigned POSITION_BITS = 20
) (
    input  wire logic signed [spf_pkg::ANGLE_W-1:0] i_angle,
    input  wire logic [spf_pkg::SPD_W-1:0]          i_steps_per_deg,
    output logic signed [POSITION_BITS-1:0]         o_steps
);

    localparam int unsigned AW = spf_pkg::ANGLE_W;
    localparam int unsigned PW = AW + spf_pkg::SPD_W;
    // wide enough for the signed quotient and for the position limits
    localparam int unsigned CW = (POSITION_BITS > AW + 1) ? POSITION_BITS + 1 : AW + 2;

    localparam logic signed [CW-1:0] POS_MAX =
        {{(CW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
    localparam logic signed [CW-1:0] POS_MIN =
        {{(CW-POSITION_BITS+1){1'b1}}, {(POSITION_BITS-1){1'b0}}};

    logic                   neg;
    logic [AW-1:0]          mag;
    logic [PW-1:0]          prod;
    logic [AW-1:0]          quot;
    logic signed [CW-1:0]   quot_ext;
    logic signed [CW-1:0]   value;

    // magnitude, scale, drop the 24 fraction bits, restore sign
    always_comb begin
        neg      = i_angle[AW-1];
        mag      = neg ? AW'(-i_angle) : AW'(i_angle);
        prod     = PW'(mag) * PW'(i_steps_per_deg);
        quot     = prod[PW-1:spf_pkg::SPD_W];
        quot_ext = {{(CW-AW){1'b0}}, quot};
        value    = neg ? -quot_ext : quot_ext;
    end

    // clamp to the position range
    always_comb begin
        priority if (value > POS_MAX) begin
            o_steps = POS_MAX[POSITION_BITS-1:0];
        end else if (value < POS_MIN) begin
            o_steps = POS_MIN[POSITION_BITS-1:0];
        end else begin
            o_steps = value[POSITION_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

@@ rtl/spf_core.sv @@
// position, goal, homing sequence and fault latch of the stepper follower
// depends on spf_pkg, spf_goal_scale and stepper_position_follower_assert.svh
`default_nettype none
`include "stepper_position_follower_assert.svh"

module spf_core #(
    parameter int unsigned POSITION_BITS = 20
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_fire,
    input  wire spf_pkg::t_item                      i_item,
    input  wire logic [spf_pkg::SPD_W-1:0]           i_steps_per_deg,
    input  wire logic [spf_pkg::CALDIV_W-1:0]        i_cal_divider,
    output spf_pkg::t_flags                          o_flags,
    output logic signed [POSITION_BITS-1:0]          o_position,
    output logic signed [POSITION_BITS-1:0]          o_goal,
    output logic signed [POSITION_BITS-1:0]          o_left_end,
    output logic signed [POSITION_BITS-1:0]          o_right_end
);

    localparam int unsigned W  = POSITION_BITS;
    localparam int unsigned EW = POSITION_BITS + 2;
    localparam int unsigned DW = spf_pkg::CALDIV_W;

    localparam logic signed [EW-1:0] POS_MAX = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] POS_MIN = {3'b111, {(W-1){1'b0}}};

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEFT  = 2'd1,
        PH_RIGHT = 2'd2
    } t_phase;

    function automatic logic signed [EW-1:0] ext(input logic signed [W-1:0] x);
        return {{2{x[W-1]}}, x};
    endfunction

    function automatic logic signed [W-1:0] sat_pos(input logic signed [EW-1:0] x);
        logic signed [W-1:0] r;
        priority if (x > POS_MAX) begin
            r = POS_MAX[W-1:0];
        end else if (x < POS_MIN) begin
            r = POS_MIN[W-1:0];
        end else begin
            r = x[W-1:0];
        end
        return r;
    endfunction

    logic signed [W-1:0] r_cur, r_goal, r_lend, r_rend;
    logic signed [W-1:0] n_cur, n_goal, n_lend, n_rend;
    logic                r_fault, n_fault;
    logic                r_dir, n_dir;
    logic                r_pulse, n_pulse;
    t_phase              r_phase, n_phase;
    logic [DW-1:0]       r_cnt, n_cnt;

    logic signed [W-1:0]  scaled;
    logic [DW-1:0]        div_eff;
    logic [DW-1:0]        cnt_inc;
    logic                 ramp_due;
    logic signed [EW-1:0] end_sum;
    logic signed [EW-1:0] end_sum_adj;
    logic signed [EW-1:0] offset;

    spf_goal_scale #(
        .POSITION_BITS (POSITION_BITS)
    ) u_goal_scale (
        .i_angle         (i_item.angle),
        .i_steps_per_deg (i_steps_per_deg),
        .o_steps         (scaled)
    );

    // ramp pacing: divider of zero behaves as one
    always_comb begin
        div_eff  = (i_cal_divider == '0) ? DW'(1) : i_cal_divider;
        cnt_inc  = r_cnt + DW'(1);
        ramp_due = (cnt_inc >= div_eff);
    end

    // midpoint of the ends, truncated toward zero
    always_comb begin
        end_sum     = ext(r_lend) + ext(r_goal);
        end_sum_adj = end_sum + {{(EW-1){1'b0}}, end_sum[EW-1]};
        offset      = end_sum_adj >>> 1;
    end

    // next state for one beat
    always_comb begin
        n_cur   = r_cur;
        n_goal  = r_goal;
        n_lend  = r_lend;
        n_rend  = r_rend;
        n_fault = r_fault | i_item.alarm_active;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_dir   = r_dir;
        n_pulse = 1'b0;
        unique case (i_item.kind)
            spf_pkg::KIND_TICK: begin
                // one step toward the old goal unless that side's switch is pressed
                if (r_cur < r_goal) begin
                    if (!i_item.left_switch) begin
                        n_dir   = 1'b0;
                        n_cur   = r_cur + W'(1);
                        n_pulse = 1'b1;
                    end
                end else if (r_cur > r_goal) begin
                    if (!i_item.right_switch) begin
                        n_dir   = 1'b1;
                        n_cur   = r_cur - W'(1);
                        n_pulse = 1'b1;
                    end
                end
                // homing sequence
                unique case (r_phase)
                    PH_LEFT: begin
                        if (i_item.left_switch) begin
                            n_lend  = r_goal;
                            n_phase = PH_RIGHT;
                            n_cnt   = '0;
                        end else if (ramp_due) begin
                            n_cnt  = '0;
                            n_goal = sat_pos(ext(r_goal) + EW'(1));
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    PH_RIGHT: begin
                        if (i_item.right_switch) begin
                            // recentre everything about the midpoint
                            n_cur   = sat_pos(ext(n_cur) - offset);
                            n_lend  = sat_pos(ext(r_lend) - offset);
                            n_rend  = sat_pos(ext(r_goal) - offset);
                            n_goal  = '0;
                            n_phase = PH_IDLE;
                            n_cnt   = '0;
                        end else if (ramp_due) begin
                            n_cnt  = '0;
                            n_goal = sat_pos(ext(r_goal) - EW'(1));
                        end else begin
                            n_cnt = cnt_inc;
                        end
                    end
                    PH_IDLE: begin
                    end
                    default: begin
                    end
                endcase
            end
            spf_pkg::KIND_SET_GOAL: begin
                if (r_phase == PH_IDLE) begin
                    n_goal = scaled;
                end
            end
            spf_pkg::KIND_CALIBRATE: begin
                if (r_phase == PH_IDLE) begin
                    n_phase = PH_LEFT;
                    n_cnt   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // state doubles as the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_goal  <= '0;
            r_lend  <= '0;
            r_rend  <= '0;
            r_fault <= 1'b0;
            r_phase <= PH_IDLE;
            r_cnt   <= '0;
            r_dir   <= 1'b0;
            r_pulse <= 1'b0;
        end else if (i_fire) begin
            r_cur   <= n_cur;
            r_goal  <= n_goal;
            r_lend  <= n_lend;
            r_rend  <= n_rend;
            r_fault <= n_fault;
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_dir   <= n_dir;
            r_pulse <= n_pulse;
        end
    end

    // result fields
    always_comb begin
        o_flags.step_pulse  = r_pulse;
        o_flags.direction   = r_dir;
        o_flags.fault       = r_fault;
        o_flags.calibrating = (r_phase != PH_IDLE);
        o_position          = r_cur;
        o_goal              = r_goal;
        o_left_end          = r_lend;
        o_right_end         = r_rend;
    end

    // checks
    `SPF_ASSERT(a_fault_sticks, i_clk, i_rst_n, r_fault |=> r_fault, "fault latch dropped")
    `SPF_ASSERT(a_state_holds, i_clk, i_rst_n, !i_fire |=> ($stable(r_cur) && $stable(r_goal) && $stable(r_phase)), "state moved without a beat")
    `SPF_ASSERT(a_idle_count, i_clk, i_rst_n, (r_phase == PH_IDLE) |-> (r_cnt == '0), "ramp counter running while idle")
    `SPF_ASSERT(a_no_step_off_tick, i_clk, i_rst_n, (i_fire && (i_item.kind != spf_pkg::KIND_TICK)) |=> !r_pulse, "step issued on a non-tick beat")

endmodule

`default_nettype wire

@@ rtl/stepper_position_follower.sv @@
// top level of the stepper position follower: handshakes, input register, configuration
// depends on spf_pkg and spf_core
`default_nettype none

// Stepper follower with limit-switch homing. One input beat is accepted per
// clock unless a stalled result holds it off; each beat yields exactly one
// result beat: it is captured in the input register, then the step decision,
// goal conversion (a single 16x24 multiply) and homing update run combinationally
// into the state registers, which are also the result register. A stalled
// result holds the pipeline; the input register still takes one more beat.
// Configuration writes are registered and are meant for idle periods.
module stepper_position_follower #(
    parameter int unsigned POSITION_BITS = 20
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // input channel
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [1:0]                           i_kind,
    input  wire logic signed [spf_pkg::ANGLE_W-1:0]   i_angle,
    input  wire logic                                 i_left_switch,
    input  wire logic                                 i_right_switch,
    input  wire logic                                 i_alarm_active,
    // result channel
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic                                      o_step_pulse,
    output logic                                      o_direction,
    output logic signed [POSITION_BITS-1:0]           o_position,
    output logic signed [POSITION_BITS-1:0]           o_goal,
    output logic                                      o_fault,
    output logic                                      o_calibrating,
    output logic signed [POSITION_BITS-1:0]           o_left_end,
    output logic signed [POSITION_BITS-1:0]           o_right_end,
    // configuration write port
    input  wire logic                                 i_cfg_we,
    input  wire logic [spf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [spf_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic                                r_in_valid;
    spf_pkg::t_item                      r_item;
    logic                                r_out_valid;
    logic [spf_pkg::SPD_W-1:0]           r_steps_per_deg;
    logic [spf_pkg::CALDIV_W-1:0]        r_cal_divider;
    logic                                fire;
    spf_pkg::t_flags                     flags;

    // beat moves from the input register to the result register
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_item.kind         <= i_kind;
            r_item.angle        <= i_angle;
            r_item.left_switch  <= i_left_switch;
            r_item.right_switch <= i_right_switch;
            r_item.alarm_active <= i_alarm_active;
        end
    end

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps_per_deg <= spf_pkg::SPD_RESET;
            r_cal_divider   <= spf_pkg::CALDIV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                spf_pkg::CFG_STEPS_PER_DEG: begin
                    r_steps_per_deg <= i_cfg_data[spf_pkg::SPD_W-1:0];
                end
                spf_pkg::CFG_CAL_DIVIDER: begin
                    r_cal_divider <= i_cfg_data[spf_pkg::CALDIV_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    spf_core #(
        .POSITION_BITS (POSITION_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (fire),
        .i_item          (r_item),
        .i_steps_per_deg (r_steps_per_deg),
        .i_cal_divider   (r_cal_divider),
        .o_flags         (flags),
        .o_position      (o_position),
        .o_goal          (o_goal),
        .o_left_end      (o_left_end),
        .o_right_end     (o_right_end)
    );

    // result flags
    assign o_out_valid   = r_out_valid;
    assign o_step_pulse  = flags.step_pulse;
    assign o_direction   = flags.direction;
    assign o_fault       = flags.fault;
    assign o_calibrating = flags.calibrating;

endmodule

`default_nettype wire
